// ===== hdl/pic_pkg.sv =====
// Shared constants, action codes and scan status type for the interrupt controller.
package pic_pkg;

  localparam int DEF_NUM_SOURCES   = 96;
  localparam int DEF_PRIORITY_BITS = 5;

  // Stream payload layout
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 1;
  localparam int WADDR_W     = 20;
  localparam int DATA_W      = 32;
  localparam int SRC_W       = 7;

  // Action codes carried on in_tuser
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RAISE = 2'd2;

  // Register map, in 32-bit word addresses (byte offset / 4)
  localparam int unsigned PRIO_WBASE   = 32'h0000_0001;
  localparam int unsigned PEND_WBASE   = 32'h0000_0400;
  localparam int unsigned EN_WBASE     = 32'h0000_0800;
  localparam int unsigned THRESH_WADDR = 32'h0008_0000;
  localparam int unsigned CLAIM_WADDR  = 32'h0008_0001;

  typedef struct packed {
    logic issue;  // scanner is reading one source per cycle
    logic done;   // one-cycle pulse, best id is final
  } scan_stat_t;

endpackage

// ===== hdl/platform_interrupt_controller.sv =====
// Top level of the interrupt controller: register file, sequencer and stream ports.
//
// Usage: every input transfer is one step - a bus read, a bus write, or a
// source raising its request (kind on in_tuser). Every step gives exactly
// one output transfer: read data, the hart interrupt line after the step,
// and a bad-address flag on out_tuser.
// After reset the block runs a clearing sweep over the priority RAM, one
// entry per cycle, with in_tready low.
// Every step ends with a full priority scan for the hart line, which reads
// the priority RAM one source per cycle through its single read port and
// one comparator; a priority read first waits for the RAM read data, and a
// claim read runs two scans (pick the winner, then recompute the line).
// One step is in flight at a time, so the next input transfer is taken
// only after the previous step has finished.
// in_tready is high only when the sequencer is idle. The result sits in an
// output register; if the receiver stalls, the next step still runs, then
// waits with in_tready low until that register has been handed off.
module platform_interrupt_controller #(
  parameter int NUM_SOURCES   = pic_pkg::DEF_NUM_SOURCES,
  parameter int PRIORITY_BITS = pic_pkg::DEF_PRIORITY_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [21:0] address, [53:22] write_data, [60:54] source_id, rest zero
  input  logic [pic_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] action
  input  logic [pic_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] read_data, [32] irq_out, rest zero
  output logic [pic_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] bad_address
  output logic [pic_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import pic_pkg::*;

  // ids are at least 6 bits so an id always splits into word and bit parts
  localparam int IDX_W      = ($clog2(NUM_SOURCES) > 6) ? $clog2(NUM_SOURCES) : 6;
  localparam int WIDX_W     = IDX_W - 5;
  localparam int VEC_W      = 1 << IDX_W;
  localparam int WORD_COUNT = (NUM_SOURCES + 31) / 32;
  localparam int RAM_AW     = $clog2(NUM_SOURCES);
  // bits of real sources 1..NUM_SOURCES-1
  localparam logic [VEC_W-1:0] SRC_MASK =
    ((VEC_W'(1) << NUM_SOURCES) - VEC_W'(1)) & ~VEC_W'(1);
  localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(NUM_SOURCES - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_SCAN1  = 3'd4;
  localparam logic [2:0] ST_SCAN2  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic [RAM_AW-1:0]        clr_cnt_r, clr_cnt_nxt;

  // architectural state (flat bit vectors, one bit per source id)
  logic [VEC_W-1:0]         pend_r, pend_nxt;
  logic [VEC_W-1:0]         en_r, en_nxt;
  logic [VEC_W-1:0]         isv_r, isv_nxt;
  logic [PRIORITY_BITS-1:0] thr_r, thr_nxt;

  // current step
  logic [1:0]               it_act_r;
  logic [WADDR_W-1:0]       it_waddr_r;
  logic [DATA_W-1:0]        it_wdata_r;
  logic [SRC_W-1:0]         it_src_r;
  logic [DATA_W-1:0]        rd_r, rd_nxt;
  logic                     bad_r, bad_nxt;
  logic                     irq_r, irq_nxt;

  // output register
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_rd_r;
  logic                     out_irq_r;
  logic                     out_bad_r;
  logic                     out_free;

  logic                     in_xfer;
  logic [31:0]              wa;
  logic                     is_bus, is_wr;
  logic                     hit_prio, hit_pend, hit_en, hit_thr, hit_claim;
  logic [IDX_W-1:0]         bus_id;
  logic [WIDX_W-1:0]        bus_widx, rd_widx;
  logic                     src_ok, data_ok;
  logic [IDX_W-1:0]         src_idx, data_idx;
  logic [31:0]              pend_word, en_word, pe_word;

  logic                     ram_we;
  logic [RAM_AW-1:0]        ram_waddr, ram_raddr;
  logic [PRIORITY_BITS-1:0] ram_wdata, ram_rdata;

  scan_stat_t               sc_stat;
  logic                     sc_start;
  logic                     cand_ok;
  logic [IDX_W-1:0]         scan_id, best_id;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // address decode of the held step
  assign wa        = 32'(it_waddr_r);
  assign is_bus    = (it_act_r == ACT_READ) || (it_act_r == ACT_WRITE);
  assign is_wr     = (it_act_r == ACT_WRITE);
  assign hit_prio  = (wa >= PRIO_WBASE) && (wa < NUM_SOURCES);
  assign hit_pend  = (wa >= PEND_WBASE) && (wa < PEND_WBASE + WORD_COUNT);
  assign hit_en    = (wa >= EN_WBASE) && (wa < EN_WBASE + WORD_COUNT);
  assign hit_thr   = (wa == THRESH_WADDR);
  assign hit_claim = (wa == CLAIM_WADDR);
  assign bus_id    = it_waddr_r[IDX_W-1:0];
  // word bases have zero low bits, so the word index is the low address bits
  assign bus_widx  = it_waddr_r[WIDX_W-1:0];

  assign src_ok    = (it_src_r != '0) && (32'(it_src_r) < NUM_SOURCES);
  assign src_idx   = IDX_W'(it_src_r);
  assign data_ok   = (it_wdata_r != '0) && (it_wdata_r < NUM_SOURCES);
  assign data_idx  = it_wdata_r[IDX_W-1:0];

  // one shared word read port: scanner while issuing, bus otherwise
  assign rd_widx   = sc_stat.issue ? scan_id[IDX_W-1:5] : bus_widx;
  assign pend_word = pend_r[{rd_widx, 5'b0} +: 32];
  assign en_word   = en_r[{rd_widx, 5'b0} +: 32];
  assign pe_word   = pend_word & en_word;
  assign cand_ok   = pe_word[scan_id[4:0]];

  // priority RAM ports
  assign ram_we    = (state_r == ST_CLEAR) ||
                     ((state_r == ST_EXEC) && is_wr && hit_prio);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : bus_id[RAM_AW-1:0];
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : it_wdata_r[PRIORITY_BITS-1:0];
  assign ram_raddr = sc_stat.issue ? scan_id[RAM_AW-1:0] : bus_id[RAM_AW-1:0];

  pic_ram #(
    .WIDTH (PRIORITY_BITS),
    .DEPTH (NUM_SOURCES)
  ) u_prio_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pic_scan #(
    .NUM_SOURCES   (NUM_SOURCES),
    .PRIORITY_BITS (PRIORITY_BITS),
    .IDX_W         (IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sc_start),
    .thr      (thr_nxt),
    .cand_ok  (cand_ok),
    .prio     (ram_rdata),
    .stat     (sc_stat),
    .issue_id (scan_id),
    .best_id  (best_id)
  );

  // sequencer and register file updates
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pend_nxt    = pend_r;
    en_nxt      = en_r;
    isv_nxt     = isv_r;
    thr_nxt     = thr_r;
    rd_nxt      = rd_r;
    bad_nxt     = bad_r;
    irq_nxt     = irq_r;
    sc_start    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + RAM_AW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_nxt    = '0;
        bad_nxt   = is_bus && !(hit_prio || hit_pend || hit_en || hit_thr || hit_claim);
        state_nxt = ST_SCAN2;
        sc_start  = 1'b1;
        if (it_act_r == ACT_RAISE) begin
          // raise from an in-service source is dropped
          if (src_ok && !isv_r[src_idx]) begin
            pend_nxt[src_idx] = 1'b1;
          end
        end else if (is_bus) begin
          if (hit_prio) begin
            if (!is_wr) begin
              state_nxt = ST_RDWAIT;
              sc_start  = 1'b0;
            end
          end else if (hit_pend) begin
            if (is_wr) begin
              pend_nxt[{bus_widx, 5'b0} +: 32] =
                it_wdata_r & SRC_MASK[{bus_widx, 5'b0} +: 32];
            end else begin
              rd_nxt = pend_word;
            end
          end else if (hit_en) begin
            if (is_wr) begin
              en_nxt[{bus_widx, 5'b0} +: 32] =
                it_wdata_r & SRC_MASK[{bus_widx, 5'b0} +: 32];
            end else begin
              rd_nxt = en_word;
            end
          end else if (hit_thr) begin
            if (is_wr) begin
              thr_nxt = it_wdata_r[PRIORITY_BITS-1:0];
            end else begin
              rd_nxt = 32'(thr_r);
            end
          end else if (hit_claim) begin
            if (is_wr) begin
              if (data_ok) begin
                isv_nxt[data_idx] = 1'b0;
              end
            end else begin
              state_nxt = ST_SCAN1;
            end
          end
        end
      end
      ST_RDWAIT: begin
        rd_nxt    = 32'(ram_rdata);
        sc_start  = 1'b1;
        state_nxt = ST_SCAN2;
      end
      ST_SCAN1: begin
        if (sc_stat.done) begin
          rd_nxt = 32'(best_id);
          if (best_id != '0) begin
            pend_nxt[best_id] = 1'b0;
            isv_nxt[best_id]  = 1'b1;
          end
          sc_start  = 1'b1;
          state_nxt = ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        if (sc_stat.done) begin
          irq_nxt   = (best_id != '0);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= '0;
      en_r        <= '0;
      isv_r       <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pend_r    <= pend_nxt;
      en_r      <= en_nxt;
      isv_r     <= isv_nxt;
      thr_r     <= thr_nxt;
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r  <= rd_nxt;
    bad_r <= bad_nxt;
    irq_r <= irq_nxt;
    if (in_xfer) begin
      it_act_r   <= in_tuser;
      it_waddr_r <= in_tdata[21:2];
      it_wdata_r <= in_tdata[53:22];
      it_src_r   <= in_tdata[60:54];
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_rd_r  <= rd_r;
      out_irq_r <= irq_r;
      out_bad_r <= bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_irq_r, out_rd_r};
  assign out_tuser  = out_bad_r;

  // no bit for source zero or past the last source is ever set
  a_src_mask: assert property (@(posedge clk) disable iff (!rst_n)
    ((pend_r & ~SRC_MASK) == '0) && ((en_r & ~SRC_MASK) == '0) &&
    ((isv_r & ~SRC_MASK) == '0))
    else $error("bit set outside the source range");

  // a granted claim moves the source from pending to in service
  a_claim: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN1) && sc_stat.done && (best_id != '0)) |=>
      (isv_r[$past(best_id)] && !pend_r[$past(best_id)]))
    else $error("claimed source not marked in service");

  // priority RAM is written only by the clear sweep or a bus write
  a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_CLEAR) || (state_r == ST_EXEC)))
    else $error("priority RAM written outside clear or execute");

  // scanner owns the RAM read port only during the scan states
  a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
    sc_stat.issue |-> ((state_r == ST_SCAN1) || (state_r == ST_SCAN2)))
    else $error("scan running outside a scan state");

endmodule

// ===== hdl/pic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/pic_scan.sv =====
// Priority scanner: walks source ids one per cycle through a single compare unit.
module pic_scan #(
  parameter int NUM_SOURCES   = 96,
  parameter int PRIORITY_BITS = 5,
  parameter int IDX_W         = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [PRIORITY_BITS-1:0] thr,
  input  logic                     cand_ok,   // pending & enabled for issue_id
  input  logic [PRIORITY_BITS-1:0] prio,      // RAM data for the id issued the cycle before
  output pic_pkg::scan_stat_t      stat,
  output logic [IDX_W-1:0]         issue_id,
  output logic [IDX_W-1:0]         best_id
);
  import pic_pkg::*;

  localparam logic [IDX_W-1:0] LAST_ID = IDX_W'(NUM_SOURCES - 1);

  logic [IDX_W-1:0]         cnt_r;
  logic                     iss_r;
  logic                     chk_r;
  logic                     chk_ok_r;
  logic [IDX_W-1:0]         chk_id_r;
  logic [IDX_W-1:0]         best_id_r;
  logic [PRIORITY_BITS-1:0] best_pri_r;
  logic                     done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r  <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= chk_r && (chk_id_r == LAST_ID);
      if (start) begin
        iss_r <= 1'b1;
        chk_r <= 1'b0;
      end else begin
        chk_r <= iss_r;
        if (iss_r && (cnt_r == LAST_ID)) begin
          iss_r <= 1'b0;
        end
      end
    end
  end

  // strict compare keeps the lowest id on ties
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r      <= IDX_W'(1);
      best_id_r  <= '0;
      best_pri_r <= thr;
    end else begin
      if (iss_r) begin
        cnt_r    <= cnt_r + IDX_W'(1);
        chk_ok_r <= cand_ok;
        chk_id_r <= cnt_r;
      end
      if (chk_r && chk_ok_r && (prio > best_pri_r)) begin
        best_id_r  <= chk_id_r;
        best_pri_r <= prio;
      end
    end
  end

  assign issue_id   = cnt_r;
  assign best_id    = best_id_r;
  assign stat.issue = iss_r;
  assign stat.done  = done_r;

endmodule

// ===== tb/platform_interrupt_controller_tb.sv =====
// Self-checking stream testbench for the platform interrupt controller.
module platform_interrupt_controller_tb;
  import pic_pkg::*;

  localparam int NSRC   = DEF_NUM_SOURCES;
  localparam int PBITS  = DEF_PRIORITY_BITS;
  localparam int NWORDS = (NSRC + 31) / 32;

  // action code with no function; the block must answer it with zero read data and no bad-address flag
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // byte addresses derived from the word map in the package
  localparam logic [21:0] PEND_ADDR   = 22'(PEND_WBASE << 2);
  localparam logic [21:0] EN_ADDR     = 22'(EN_WBASE << 2);
  localparam logic [21:0] THRESH_ADDR = 22'(THRESH_WADDR << 2);
  localparam logic [21:0] CLAIM_ADDR  = 22'(CLAIM_WADDR << 2);

  // a claim runs two full scans; the tail wait covers a few of those
  localparam int CLAIM_CYCLES = 2 * NSRC + 5;
  localparam int TAIL_CYCLES  = 4 * CLAIM_CYCLES;
  // long receiver hold-off, well past one finished step
  localparam int HOLD_CYCLES  = 3 * CLAIM_CYCLES;
  // ~1500 transfers at worst claim latency plus receiver stalls and sender
  // gaps are meant to stay well below this cap
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_PER_PHASE = 480;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        bad_address;
  } pic_reply_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // [21:0] address, [53:22] write_data, [60:54] source_id
  logic [IN_TUSER_W-1:0] in_tuser;   // [1:0] action
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata; // [31:0] read_data, [32] irq_out
  logic [OUT_TUSER_W-1:0] out_tuser; // [0] bad_address

  platform_interrupt_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the controller state
  // ---------------------------------------------------------------------
  logic [PBITS-1:0]       prio_tbl [NSRC];
  logic [NWORDS*32-1:0]   pend_bits;
  logic [NWORDS*32-1:0]   en_bits;
  logic [NWORDS*32-1:0]   svc_bits;
  logic [NWORDS*32-1:0]   src_mask;   // 1 for ids 1..NSRC-1
  logic [PBITS-1:0]       thresh_lvl;

  pic_reply_t replies_due [$];

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  int hold_left;
  int cycles;
  int errors;
  int transfers_in;
  int replies_checked;
  int claims_granted;
  int irq_high_seen;

  // highest-priority enabled pending source above threshold, lowest id wins
  function automatic int winning_source();
    int best;
    int best_lvl;
    best = 0;
    best_lvl = thresh_lvl;
    for (int i = 1; i < NSRC; i++)
      if (pend_bits[i] && en_bits[i] && prio_tbl[i] > best_lvl) begin
        best = i;
        best_lvl = prio_tbl[i];
      end
    return best;
  endfunction

  // applies one step to the shadow state and returns the reply it gives
  function automatic pic_reply_t predict_reply(logic [1:0] act, logic [21:0] addr,
                                               logic [31:0] wdata, logic [6:0] src);
    pic_reply_t r;
    logic [19:0] wa;
    bit wr;
    int w;
    int id;
    r = '0;
    wa = addr[21:2];
    wr = (act == ACT_WRITE);
    if (act == ACT_RAISE) begin
      // raise while in service is dropped
      if (src >= 1 && src < NSRC && !svc_bits[src])
        pend_bits[src] = 1'b1;
    end else if (act == ACT_READ || act == ACT_WRITE) begin
      if (wa >= PRIO_WBASE && wa < NSRC) begin
        if (wr) prio_tbl[wa] = wdata[PBITS-1:0];
        else r.read_data = 32'(prio_tbl[wa]);
      end else if (wa >= PEND_WBASE && wa < PEND_WBASE + NWORDS) begin
        w = wa - PEND_WBASE;
        // pending write replaces the word, in-service or not
        if (wr) pend_bits[32*w +: 32] = wdata & src_mask[32*w +: 32];
        else r.read_data = pend_bits[32*w +: 32];
      end else if (wa >= EN_WBASE && wa < EN_WBASE + NWORDS) begin
        w = wa - EN_WBASE;
        if (wr) en_bits[32*w +: 32] = wdata & src_mask[32*w +: 32];
        else r.read_data = en_bits[32*w +: 32];
      end else if (wa == THRESH_WADDR) begin
        if (wr) thresh_lvl = wdata[PBITS-1:0];
        else r.read_data = 32'(thresh_lvl);
      end else if (wa == CLAIM_WADDR) begin
        if (wr) begin
          if (wdata >= 1 && wdata < NSRC) svc_bits[wdata] = 1'b0;
        end else begin
          id = winning_source();
          if (id != 0) begin
            pend_bits[id] = 1'b0;
            svc_bits[id] = 1'b1;
            claims_granted++;
          end
          r.read_data = 32'(id);
        end
      end else begin
        r.bad_address = 1'b1;
      end
    end
    r.irq = (winning_source() != 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: one input transfer; starts and ends at a falling edge
  // ---------------------------------------------------------------------
  task automatic send_step(logic [1:0] act, logic [21:0] addr, logic [31:0] wdata,
                           logic [6:0] src);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, src, wdata, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    replies_due.push_back(predict_reply(act, addr, wdata, src));
    transfers_in++;
    @(negedge clk);
  endtask

  // sender stops until every reply has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls plus an on-demand long hold-off
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
  endtask

  // checks each output transfer against the oldest predicted reply
  pic_reply_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: output transfer with none expected, expected none actual %h/%h",
                 $time, out_tdata, out_tuser);
      end else begin
        want = replies_due.pop_front();
        if (out_tdata[31:0] !== want.read_data)
          report_mismatch("read_data", want.read_data, out_tdata[31:0]);
        if (out_tdata[32] !== want.irq)
          report_mismatch("irq_out", 32'(want.irq), 32'(out_tdata[32]));
        if (out_tuser[0] !== want.bad_address)
          report_mismatch("bad_address", 32'(want.bad_address), 32'(out_tuser[0]));
        if (want.irq) irq_high_seen++;
        replies_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d replies outstanding",
               $time, cycles, replies_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // priority, threshold and enable registers: wide writes truncate,
  // bit of source zero stays clear
  task automatic test_register_access();
    send_step(ACT_READ,  22'(4 * 1), 32'h0, 7'd0);
    send_step(ACT_WRITE, 22'(4 * 1), 32'hFFFF_FFFF, 7'd0);
    send_step(ACT_READ,  22'(4 * 1) | 22'h3, 32'h0, 7'd0);
    send_step(ACT_WRITE, 22'(4 * (NSRC - 1)), 32'h0000_001F, 7'd0);
    send_step(ACT_WRITE, THRESH_ADDR, 32'hFFFF_FFE3, 7'd0);
    send_step(ACT_READ,  THRESH_ADDR, 32'h0, 7'd0);
    send_step(ACT_WRITE, EN_ADDR, 32'hFFFF_FFFF, 7'd0);
    send_step(ACT_WRITE, 22'(EN_ADDR + 4 * (NWORDS - 1)), 32'hFFFF_FFFF, 7'd0);
  endtask

  // raises, tie-break by lowest id, dropped raise while in service,
  // ignored completions, pending word replace, priority zero
  task automatic test_claim_complete();
    send_step(ACT_RAISE, 22'h0, 32'h0, 7'd0);
    send_step(ACT_RAISE, 22'h0, 32'h0, 7'd127);
    send_step(ACT_RAISE, 22'h0, 32'h0, 7'd1);
    send_step(ACT_RAISE, 22'h3F_FFFF, 32'hFFFF_FFFF, 7'(NSRC - 1));
    send_step(ACT_READ,  CLAIM_ADDR, 32'h0, 7'd0);
    send_step(ACT_RAISE, 22'h0, 32'h0, 7'd1);
    send_step(ACT_READ,  CLAIM_ADDR, 32'h0, 7'd0);
    send_step(ACT_WRITE, CLAIM_ADDR, 32'h0, 7'd0);
    send_step(ACT_WRITE, CLAIM_ADDR, 32'(NSRC), 7'd0);
    send_step(ACT_WRITE, CLAIM_ADDR, 32'd1, 7'd0);
    send_step(ACT_WRITE, PEND_ADDR, 32'hFFFF_FFFF, 7'd0);
    send_step(ACT_WRITE, 22'(4 * 1), 32'h0, 7'd0);
    send_step(ACT_READ,  CLAIM_ADDR, 32'h0, 7'd0);
    send_step(ACT_READ,  PEND_ADDR, 32'h0, 7'd0);
  endtask

  // unmapped offsets answer zero with the flag set; unused action is inert
  task automatic test_bad_access();
    send_step(ACT_READ,   22'h0, 32'h0, 7'd0);
    send_step(ACT_WRITE,  22'h0, 32'hFFFF_FFFF, 7'd0);
    send_step(ACT_READ,   22'(PEND_ADDR + 4 * NWORDS), 32'h0, 7'd0);
    send_step(ACT_READ,   22'h3F_FFFF, 32'h0, 7'd0);
    send_step(ACT_UNUSED, CLAIM_ADDR, 32'h0, 7'd1);
  endtask

  // receiver holds off while the sender keeps offering; input must stall
  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) send_step(ACT_RAISE, 22'h0, 32'h0, 7'($urandom_range(NSRC - 1, 1)));
      else send_step(ACT_READ, CLAIM_ADDR, 32'h0, 7'd0);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------

  // mostly a source that really is in service, sometimes junk
  function automatic logic [31:0] completion_id();
    int ids [$];
    for (int i = 1; i < NSRC; i++)
      if (svc_bits[i]) ids.push_back(i);
    if (ids.size() != 0 && $urandom_range(4) != 0)
      return 32'(ids[$urandom_range(ids.size() - 1)]);
    return ($urandom_range(1) != 0) ? 32'($urandom_range(127)) : $urandom;
  endfunction

  task automatic random_step();
    int pick;
    logic [1:0]  act;
    logic [21:0] addr;
    logic [31:0] data;
    logic [6:0]  src;
    pick = $urandom_range(99);
    act  = ACT_READ;
    addr = 22'($urandom);
    data = $urandom;
    src  = 7'($urandom_range(127));
    if (pick < 30) begin
      act = ACT_RAISE;
      if ($urandom_range(9) != 0) src = 7'($urandom_range(NSRC - 1, 1));
    end else if (pick < 45) begin
      addr = CLAIM_ADDR;
    end else if (pick < 58) begin
      act = ACT_WRITE;
      addr = CLAIM_ADDR;
      data = completion_id();
    end else if (pick < 68) begin
      act = ACT_WRITE;
      addr = 22'(4 * $urandom_range(NSRC - 1, 1));
    end else if (pick < 73) begin
      act = ACT_WRITE;
      addr = 22'(EN_ADDR + 4 * $urandom_range(NWORDS - 1));
      if ($urandom_range(2) == 0) data = 32'hFFFF_FFFF;
    end else if (pick < 77) begin
      act = ACT_WRITE;
      addr = THRESH_ADDR;
      if ($urandom_range(3) != 0) data = 32'($urandom_range(6));
    end else if (pick < 80) begin
      act = ACT_WRITE;
      addr = 22'(PEND_ADDR + 4 * $urandom_range(NWORDS - 1));
    end else if (pick < 90) begin
      case ($urandom_range(3))
        0: addr = 22'(4 * $urandom_range(NSRC - 1, 1));
        1: addr = 22'(PEND_ADDR + 4 * $urandom_range(NWORDS - 1));
        2: addr = 22'(EN_ADDR + 4 * $urandom_range(NWORDS - 1));
        default: addr = THRESH_ADDR;
      endcase
    end else if (pick < 96) begin
      act = ($urandom_range(1) != 0) ? ACT_WRITE : ACT_READ;
    end else begin
      act = 2'($urandom_range(3));
    end
    // low address bits are don't-care everywhere
    addr[1:0] = 2'($urandom_range(3));
    send_step(act, addr, data, src);
  endtask

  // three idle profiles: slow receiver, slow sender, then none
  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 13; rx_idle_pct = 88; end
        1: begin tx_idle_pct = 88; rx_idle_pct = 13; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) random_step();
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    cycles = 0;
    errors = 0;
    transfers_in = 0;
    replies_checked = 0;
    claims_granted = 0;
    irq_high_seen = 0;
    for (int i = 0; i < NSRC; i++) prio_tbl[i] = '0;
    pend_bits = '0;
    en_bits = '0;
    svc_bits = '0;
    thresh_lvl = '0;
    src_mask = '0;
    for (int i = 1; i < NSRC; i++) src_mask[i] = 1'b1;
    tx_idle_pct = 13;
    rx_idle_pct = 88;

    // block runs its priority clearing sweep after this; sender just waits
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_claim_complete();
    test_bad_access();
    wait_drained();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d input transfers (%0d claims granted), %0d replies checked,",
             transfers_in, claims_granted, replies_checked);
    $display("irq high in %0d replies; with long output hold-off and three idle profiles",
             irq_high_seen);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d replies never arrived", errors, replies_due.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
